FILE: rtl/i2c_ras_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Types and constants shared by the sequencer core and the top level.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b0_0000_0001,
    PH_START    = 9'b0_0000_0010,
    PH_SLAW     = 9'b0_0000_0100,
    PH_REG      = 9'b0_0000_1000,
    PH_RSTART   = 9'b0_0001_0000,
    PH_SLAR     = 9'b0_0010_0000,
    PH_RXDATA   = 9'b0_0100_0000,
    PH_NEEDBYTE = 9'b0_1000_0000,
    PH_TXDATA   = 9'b1_0000_0000
  } phase_t;

  localparam logic [2:0] OP_BEGIN_RD = 3'd0;
  localparam logic [2:0] OP_BEGIN_WR = 3'd1;
  localparam logic [2:0] OP_STATUS   = 3'd2;
  localparam logic [2:0] OP_TX_BYTE  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_CONT  = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_RESET = 3'd4;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TIMEOUT   = 4'd1;
  localparam logic [3:0] ERR_BUS       = 4'd2;
  localparam logic [3:0] ERR_NACK      = 4'd3;
  localparam logic [3:0] ERR_ARB_LOST  = 4'd4;
  localparam logic [3:0] ERR_START     = 4'd5;
  localparam logic [3:0] ERR_SLAW      = 4'd6;
  localparam logic [3:0] ERR_TX        = 4'd7;
  localparam logic [3:0] ERR_RSTART    = 4'd8;
  localparam logic [3:0] ERR_SLAR      = 4'd9;
  localparam logic [3:0] ERR_RX        = 4'd10;
  localparam logic [3:0] ERR_NO_INFO   = 4'd11;

  localparam logic [7:0] ST_BUS_ERR    = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_TX_ACK     = 8'h28;
  localparam logic [7:0] ST_TX_NACK    = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] ST_NO_INFO    = 8'hF8;

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  dev_address;
    logic [7:0]  reg_index;
    logic [15:0] byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic       ack_next;
    logic       load_data;
    logic [7:0] data_out;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       need_byte;
    logic       done_res;
    logic       ok;
    logic [3:0] error_code;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_read;
    logic [6:0]  target_address;
    logic [7:0]  first_register;
    logic [15:0] bytes_left;
    logic [7:0]  wait_timer;
    logic [3:0]  last_fault;
  } seq_state_t;

endpackage

FILE: rtl/i2c_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Sequences register reads and writes on a byte-level I2C master unit.
//
//   Channel   Direction   Handshake                 Payload
//   in_       input       in_valid / in_ready       in_data  (in_item_t)
//   out_      output      out_valid / out_ready     out_data (out_item_t)
//   cfg_      input       cfg_valid / cfg_ready     cfg_data (timeout ticks)
//
// One transaction is accepted per cycle unless the result side stalls.
// The input register and the result register each hold one transaction.
// A stall on the result side holds the input register and then drops in_ready.
// Reset is synchronous; the timeout register resets to 100 ticks.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer
  import i2c_ras_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res;
  logic [7:0] timeout_r;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  i2c_ras_core u_core (
    .st            (st_r),
    .timeout_ticks (timeout_r),
    .item          (in_item_r),
    .st_nxt        (st_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      st_r        <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

endmodule

FILE: rtl/i2c_ras_core.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer core
// Next-state and result logic for one transaction item.
// ----------------------------------------------------------------------------
module i2c_ras_core
  import i2c_ras_pkg::*;
(
  input  seq_state_t st,
  input  logic [7:0] timeout_ticks,
  input  in_item_t   item,
  output seq_state_t st_nxt,
  output out_item_t  res
);

  logic        awaiting;
  logic [7:0]  stat;
  logic [15:0] bytes_dec;

  always_comb begin
    awaiting  = (st.phase != PH_IDLE) && (st.phase != PH_NEEDBYTE);
    stat      = {item.status_code[7:3], 3'b000};
    bytes_dec = (st.bytes_left != 16'd0) ? (st.bytes_left - 16'd1) : 16'd0;
    st_nxt    = st;
    res       = '0;

    case (item.op)
      OP_BEGIN_RD, OP_BEGIN_WR: begin
        if (st.phase == PH_IDLE) begin
          st_nxt.is_read        = (item.op == OP_BEGIN_RD);
          st_nxt.target_address = item.dev_address;
          st_nxt.first_register = item.reg_index;
          st_nxt.bytes_left     = item.byte_count;
          st_nxt.wait_timer     = timeout_ticks;
          st_nxt.phase          = PH_START;
          res.bus_cmd           = CMD_START;
        end
      end
      OP_STATUS: begin
        if (awaiting) begin
          case (stat)
            ST_BUS_ERR: begin
              res.bus_cmd       = CMD_STOP;
              res.done_res      = 1'b1;
              st_nxt.last_fault = ERR_BUS;
              st_nxt.phase      = PH_IDLE;
            end
            ST_SLAW_NACK, ST_SLAR_NACK, ST_TX_NACK: begin
              res.bus_cmd       = CMD_STOP;
              res.done_res      = 1'b1;
              st_nxt.last_fault = ERR_NACK;
              st_nxt.phase      = PH_IDLE;
            end
            ST_ARB_LOST: begin
              res.bus_cmd       = CMD_CONT;
              res.done_res      = 1'b1;
              st_nxt.last_fault = ERR_ARB_LOST;
              st_nxt.phase      = PH_IDLE;
            end
            ST_NO_INFO: begin
              res.done_res      = 1'b1;
              st_nxt.last_fault = ERR_NO_INFO;
              st_nxt.phase      = PH_IDLE;
            end
            default: begin
              st_nxt.last_fault = ERR_NONE;
              case (st.phase)
                PH_START: begin
                  if (stat != ST_START) begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_START;
                    st_nxt.phase      = PH_IDLE;
                  end else begin
                    res.load_data     = 1'b1;
                    res.data_out      = {st.target_address, 1'b0};
                    res.bus_cmd       = CMD_CONT;
                    st_nxt.wait_timer = timeout_ticks;
                    st_nxt.phase      = PH_SLAW;
                  end
                end
                PH_SLAW: begin
                  if (stat != ST_SLAW_ACK) begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_SLAW;
                    st_nxt.phase      = PH_IDLE;
                  end else begin
                    res.load_data     = 1'b1;
                    res.data_out      = st.first_register;
                    res.bus_cmd       = CMD_CONT;
                    st_nxt.wait_timer = timeout_ticks;
                    st_nxt.phase      = PH_REG;
                  end
                end
                PH_REG, PH_TXDATA: begin
                  if (stat != ST_TX_ACK) begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_TX;
                    st_nxt.phase      = PH_IDLE;
                  end else if ((st.phase == PH_REG) && st.is_read) begin
                    res.bus_cmd       = CMD_START;
                    st_nxt.wait_timer = timeout_ticks;
                    st_nxt.phase      = PH_RSTART;
                  end else if (st.bytes_left != 16'd0) begin
                    res.need_byte     = 1'b1;
                    st_nxt.phase      = PH_NEEDBYTE;
                  end else begin
                    res.bus_cmd       = CMD_STOP;
                    res.done_res      = 1'b1;
                    res.ok            = 1'b1;
                    st_nxt.phase      = PH_IDLE;
                  end
                end
                PH_RSTART: begin
                  if (stat != ST_RSTART) begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_RSTART;
                    st_nxt.phase      = PH_IDLE;
                  end else begin
                    res.load_data     = 1'b1;
                    res.data_out      = {st.target_address, 1'b1};
                    res.bus_cmd       = CMD_CONT;
                    st_nxt.wait_timer = timeout_ticks;
                    st_nxt.phase      = PH_SLAR;
                  end
                end
                PH_SLAR: begin
                  if (stat != ST_SLAR_ACK) begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_SLAR;
                    st_nxt.phase      = PH_IDLE;
                  end else begin
                    res.ack_next      = (st.bytes_left > 16'd1);
                    res.bus_cmd       = CMD_CONT;
                    st_nxt.wait_timer = timeout_ticks;
                    st_nxt.phase      = PH_RXDATA;
                  end
                end
                PH_RXDATA: begin
                  if (stat == ST_RX_ACK) begin
                    res.rx_valid      = 1'b1;
                    res.rx_data       = item.rx_byte;
                    res.ack_next      = (bytes_dec > 16'd1);
                    res.bus_cmd       = CMD_CONT;
                    st_nxt.bytes_left = bytes_dec;
                    st_nxt.wait_timer = timeout_ticks;
                  end else if (stat == ST_RX_NACK) begin
                    res.rx_valid      = 1'b1;
                    res.rx_data       = item.rx_byte;
                    res.bus_cmd       = CMD_STOP;
                    res.done_res      = 1'b1;
                    res.ok            = 1'b1;
                    st_nxt.phase      = PH_IDLE;
                  end else begin
                    res.done_res      = 1'b1;
                    st_nxt.last_fault = ERR_RX;
                    st_nxt.phase      = PH_IDLE;
                  end
                end
                default: begin
                end
              endcase
            end
          endcase
        end
      end
      OP_TX_BYTE: begin
        if (st.phase == PH_NEEDBYTE) begin
          res.load_data     = 1'b1;
          res.data_out      = item.tx_byte;
          res.bus_cmd       = CMD_CONT;
          st_nxt.bytes_left = bytes_dec;
          st_nxt.wait_timer = timeout_ticks;
          st_nxt.phase      = PH_TXDATA;
        end
      end
      OP_TICK: begin
        if (awaiting) begin
          if (st.wait_timer == 8'd0) begin
            res.bus_cmd       = CMD_RESET;
            res.done_res      = 1'b1;
            st_nxt.last_fault = ERR_TIMEOUT;
            st_nxt.phase      = PH_IDLE;
          end else begin
            st_nxt.wait_timer = st.wait_timer - 8'd1;
          end
        end
      end
      default: begin
      end
    endcase

    res.error_code = st_nxt.last_fault;
    res.busy_res   = (st_nxt.phase != PH_IDLE);
  end

endmodule

FILE: bench/i2c_ras_tb_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer scoreboard
// Predicts the response to every accepted request from a cycle-free model of
// the sequencer phases, status checks and tick timer, and compares each
// response from the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
package i2c_ras_tb_pkg;
  import i2c_ras_pkg::*;

  class access_scoreboard;
    logic [7:0]  timeout_limit;
    phase_t      seq_phase;
    logic        reading;
    logic [6:0]  slave_addr;
    logic [7:0]  reg_ptr;
    logic [15:0] remaining;
    logic [7:0]  tick_budget;
    logic [3:0]  fault;
    out_item_t   response;
    out_item_t   expected_responses[$];
    int          errors;

    function new();
      timeout_limit = TIMEOUT_RESET;
      seq_phase = PH_IDLE;
      reading = 1'b0;
      slave_addr = '0;
      reg_ptr = '0;
      remaining = '0;
      tick_budget = '0;
      fault = ERR_NONE;
      errors = 0;
    endfunction

    function void set_timeout(logic [7:0] ticks);
      timeout_limit = ticks;
    endfunction

    function bit awaiting_status();
      return seq_phase != PH_IDLE && seq_phase != PH_NEEDBYTE;
    endfunction

    function void issue_cmd(logic [2:0] cmd);
      response.bus_cmd = cmd;
      tick_budget = timeout_limit;
    endfunction

    function void end_transfer(logic [3:0] code);
      response.done_res = 1'b1;
      response.ok = (code == ERR_NONE);
      fault = code;
      seq_phase = PH_IDLE;
    endfunction

    function void write_acked();
      if (remaining > 16'd0) begin
        response.need_byte = 1'b1;
        seq_phase = PH_NEEDBYTE;
      end else begin
        response.bus_cmd = CMD_STOP;
        end_transfer(ERR_NONE);
      end
    endfunction

    function void apply_status(logic [7:0] status, logic [7:0] rx_byte);
      logic [7:0] code;
      code = status & 8'hF8;
      case (code)
        ST_BUS_ERR: begin
          response.bus_cmd = CMD_STOP;
          end_transfer(ERR_BUS);
          return;
        end
        ST_SLAW_NACK, ST_SLAR_NACK, ST_TX_NACK: begin
          response.bus_cmd = CMD_STOP;
          end_transfer(ERR_NACK);
          return;
        end
        ST_ARB_LOST: begin
          response.bus_cmd = CMD_CONT;
          end_transfer(ERR_ARB_LOST);
          return;
        end
        ST_NO_INFO: begin
          end_transfer(ERR_NO_INFO);
          return;
        end
        default: ;
      endcase
      fault = ERR_NONE;
      case (seq_phase)
        PH_START: begin
          if (code != ST_START) begin
            end_transfer(ERR_START);
          end else begin
            response.load_data = 1'b1;
            response.data_out = {slave_addr, 1'b0};
            issue_cmd(CMD_CONT);
            seq_phase = PH_SLAW;
          end
        end
        PH_SLAW: begin
          if (code != ST_SLAW_ACK) begin
            end_transfer(ERR_SLAW);
          end else begin
            response.load_data = 1'b1;
            response.data_out = reg_ptr;
            issue_cmd(CMD_CONT);
            seq_phase = PH_REG;
          end
        end
        PH_REG: begin
          if (code != ST_TX_ACK) begin
            end_transfer(ERR_TX);
          end else if (reading) begin
            issue_cmd(CMD_START);
            seq_phase = PH_RSTART;
          end else begin
            write_acked();
          end
        end
        PH_RSTART: begin
          if (code != ST_RSTART) begin
            end_transfer(ERR_RSTART);
          end else begin
            response.load_data = 1'b1;
            response.data_out = {slave_addr, 1'b1};
            issue_cmd(CMD_CONT);
            seq_phase = PH_SLAR;
          end
        end
        PH_SLAR: begin
          if (code != ST_SLAR_ACK) begin
            end_transfer(ERR_SLAR);
          end else begin
            response.ack_next = (remaining > 16'd1);
            issue_cmd(CMD_CONT);
            seq_phase = PH_RXDATA;
          end
        end
        PH_RXDATA: begin
          if (code == ST_RX_ACK) begin
            response.rx_valid = 1'b1;
            response.rx_data = rx_byte;
            if (remaining > 16'd0) remaining = remaining - 16'd1;
            response.ack_next = (remaining > 16'd1);
            issue_cmd(CMD_CONT);
          end else if (code == ST_RX_NACK) begin
            response.rx_valid = 1'b1;
            response.rx_data = rx_byte;
            response.bus_cmd = CMD_STOP;
            end_transfer(ERR_NONE);
          end else begin
            end_transfer(ERR_RX);
          end
        end
        PH_TXDATA: begin
          if (code != ST_TX_ACK) begin
            end_transfer(ERR_TX);
          end else begin
            write_acked();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(in_item_t req);
      bit waiting;
      waiting = awaiting_status();
      response = '0;
      case (req.op)
        OP_BEGIN_RD, OP_BEGIN_WR: begin
          if (seq_phase == PH_IDLE) begin
            reading = (req.op == OP_BEGIN_RD);
            slave_addr = req.dev_address;
            reg_ptr = req.reg_index;
            remaining = req.byte_count;
            issue_cmd(CMD_START);
            seq_phase = PH_START;
          end
        end
        OP_STATUS: begin
          if (waiting) apply_status(req.status_code, req.rx_byte);
        end
        OP_TX_BYTE: begin
          if (seq_phase == PH_NEEDBYTE) begin
            response.load_data = 1'b1;
            response.data_out = req.tx_byte;
            if (remaining > 16'd0) remaining = remaining - 16'd1;
            issue_cmd(CMD_CONT);
            seq_phase = PH_TXDATA;
          end
        end
        OP_TICK: begin
          if (waiting) begin
            if (tick_budget == 8'd0) begin
              response.bus_cmd = CMD_RESET;
              end_transfer(ERR_TIMEOUT);
            end else begin
              tick_budget = tick_budget - 8'd1;
            end
          end
        end
        default: ;
      endcase
      response.error_code = fault;
      response.busy_res = (seq_phase != PH_IDLE);
      expected_responses.push_back(response);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      check_field("bus_cmd", 32'(want.bus_cmd), 32'(got.bus_cmd));
      check_field("ack_next", 32'(want.ack_next), 32'(got.ack_next));
      check_field("load_data", 32'(want.load_data), 32'(got.load_data));
      check_field("data_out", 32'(want.data_out), 32'(got.data_out));
      check_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
      check_field("rx_data", 32'(want.rx_data), 32'(got.rx_data));
      check_field("need_byte", 32'(want.need_byte), 32'(got.need_byte));
      check_field("done_res", 32'(want.done_res), 32'(got.done_res));
      check_field("ok", 32'(want.ok), 32'(got.ok));
      check_field("error_code", 32'(want.error_code), 32'(got.error_code));
      check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    endfunction
  endclass

endpackage

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer testbench
// Runs a short directed sequence of register reads, writes, ignored events and
// faults, then random traffic that mostly follows well-formed bus sequences,
// under several timeout settings and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import i2c_ras_pkg::*;
  import i2c_ras_tb_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [7:0] STATUS_SET [13] = '{
    ST_BUS_ERR, ST_START, ST_RSTART, ST_SLAW_ACK, ST_SLAW_NACK, ST_TX_ACK,
    ST_TX_NACK, ST_ARB_LOST, ST_SLAR_ACK, ST_SLAR_NACK, ST_RX_ACK,
    ST_RX_NACK, ST_NO_INFO
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  access_scoreboard sb = new();
  bit no_idle = 1'b0;
  int tick_run = 0;

  i2c_register_access_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("i2c_register_access_sequencer regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_response(out_data);
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic [6:0] dev, logic [7:0] ridx,
                                         logic [15:0] count, logic [7:0] status,
                                         logic [7:0] rxb, logic [7:0] txb);
    in_item_t it;
    it.op = op;
    it.dev_address = dev;
    it.reg_index = ridx;
    it.byte_count = count;
    it.status_code = status;
    it.rx_byte = rxb;
    it.tx_byte = txb;
    return it;
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t    it;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [7:0]  good;
    int          pick;
    r1 = $urandom;
    r2 = $urandom;
    it.op = r1[2:0];
    it.dev_address = r1[9:3];
    it.reg_index = r1[17:10];
    it.status_code = r1[25:18];
    it.rx_byte = r2[7:0];
    it.tx_byte = r2[15:8];
    it.byte_count = r2[31:16];
    if (!sb.awaiting_status()) tick_run = 0;
    if (tick_run > 0) begin
      tick_run--;
      it.op = OP_TICK;
      return it;
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) return it;
    case (sb.seq_phase)
      PH_IDLE: begin
        it.op = r1[26] ? OP_BEGIN_RD : OP_BEGIN_WR;
        if (pick >= 20) it.byte_count = 16'($urandom_range(0, 4));
      end
      PH_NEEDBYTE: it.op = OP_TX_BYTE;
      default: begin
        it.op = OP_STATUS;
        if (pick == 12) begin
          tick_run = int'(sb.timeout_limit) + $urandom_range(0, 2);
          it.op = OP_TICK;
        end else if (pick < 28) begin
          it.op = OP_TICK;
        end else if (pick < 34) begin
          it.status_code[7:3] = STATUS_SET[$urandom_range(0, 12)][7:3];
        end else begin
          case (sb.seq_phase)
            PH_START:           good = ST_START;
            PH_SLAW:            good = ST_SLAW_ACK;
            PH_REG, PH_TXDATA:  good = ST_TX_ACK;
            PH_RSTART:          good = ST_RSTART;
            PH_SLAR:            good = ST_SLAR_ACK;
            default:            good = (sb.remaining > 16'd1 || pick < 38) ? ST_RX_ACK
                                                                         : ST_RX_NACK;
          endcase
          it.status_code[7:3] = good[7:3];
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] ticks);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    sb.set_timeout(ticks);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  initial begin
    logic [7:0] settings [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    settings = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 255)), 8'd2,
                 8'($urandom_range(4, 16))};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(make_item(OP_UNUSED, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_START, 8'h00, 8'h00));
    send_item(make_item(OP_TICK, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_TX_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'hA5));
    send_item(make_item(OP_BEGIN_WR, 7'h7F, 8'hFF, 16'd1, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_BEGIN_RD, 7'h12, 8'h34, 16'd9, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_TICK, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_START | 8'h07, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_SLAW_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_TX_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_NO_INFO, 8'h00, 8'h00));
    send_item(make_item(OP_TX_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_TX_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_BEGIN_RD, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_START, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_SLAW_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_TX_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_RSTART, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_SLAR_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_RX_ACK, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_RX_NACK, 8'hFF, 8'h00));
    send_item(make_item(OP_BEGIN_WR, 7'h55, 8'hAA, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_NO_INFO, 8'h00, 8'h00));
    send_item(make_item(OP_BEGIN_RD, 7'h2A, 8'h01, 16'd2, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_STATUS, 7'h00, 8'h00, 16'h0000, ST_ARB_LOST, 8'h00, 8'h00));
    stop_input();
    drain();

    write_timeout(8'd0);
    send_item(make_item(OP_BEGIN_WR, 7'h01, 8'h02, 16'd1, 8'h00, 8'h00, 8'h00));
    send_item(make_item(OP_TICK, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    stop_input();
    drain();

    for (int p = 0; p < 6; p++) begin
      write_timeout(settings[p]);
      for (int n = 0; n < 312; n++) begin
        if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_item(next_random_item());
      end
      stop_input();
      drain();
    end

    if (sb.errors == 0 && sb.expected_responses.size() == 0) begin
      $display("i2c_register_access_sequencer regression: pass");
    end else begin
      $display("i2c_register_access_sequencer regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/i2c_ras_pkg.sv
rtl/i2c_ras_core.sv
rtl/i2c_register_access_sequencer.sv
bench/i2c_ras_tb_pkg.sv
bench/testbench.sv
